// File: src/mcbq_pkg.sv
// ----------------------------------------------------------------------------
// mcbq_pkg
// Shared types and constants for the multichannel biquad low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbq_pkg;

  localparam int CHANNELS_DEFAULT     = 32;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;
  // Eight covers three arithmetic stages plus one waiting result at full rate.
  localparam int RESULT_DEPTH_DEFAULT = 8;

  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_B0      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A1      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A2      = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_PASS,    // returned unchanged, history untouched
    KIND_PRIME,   // first sample of a channel: seeds the history
    KIND_FILTER   // runs through the biquad
  } item_kind_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    item_kind_t                 kind;
    logic signed [SAMPLE_W-1:0] sample;
  } queue_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_d1;
    logic signed [SAMPLE_W-1:0] in_d2;
    logic signed [SAMPLE_W-1:0] out_d1;
    logic signed [SAMPLE_W-1:0] out_d2;
  } hist_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
  } result_t;

  typedef struct packed {
    logic [29:0]        b0;
    logic signed [31:0] a1;
    logic signed [30:0] a2;
  } coeff_t;

endpackage

`default_nettype wire

// File: src/mcbq_fifo.sv
// ----------------------------------------------------------------------------
// mcbq_fifo
// Small register-based FIFO with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wr_data,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  rd_data,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LW'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/mcbq_front.sv
// ----------------------------------------------------------------------------
// mcbq_front
// Accepts samples, tracks primed channels and tags each request with its kind.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbq_front #(
  parameter int CHANNELS = mcbq_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  input  wire logic                                 full,
  input  wire logic [mcbq_pkg::CHAN_W-1:0]          channel,
  input  wire logic signed [mcbq_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                 filter_enable,
  output logic                                      q_push,
  output mcbq_pkg::queue_item_t                     q_item
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] primed;
  logic [CW-1:0]       idx;
  logic                in_range;

  assign idx      = CW'(channel);
  assign in_range = (32'(channel) < 32'(CHANNELS));
  assign q_push   = push && !full;

  always_comb begin
    q_item.channel = channel;
    q_item.sample  = sample_in;
    if (!in_range) begin
      q_item.kind = mcbq_pkg::KIND_PASS;
    end else if (!primed[idx]) begin
      q_item.kind = mcbq_pkg::KIND_PRIME;
    end else if (filter_enable) begin
      q_item.kind = mcbq_pkg::KIND_FILTER;
    end else begin
      q_item.kind = mcbq_pkg::KIND_PASS;
    end
  end

  // Requests stay in order downstream, so marking here at accept is safe.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (q_push && in_range) begin
      primed[idx] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/mcbq_back.sv
// ----------------------------------------------------------------------------
// mcbq_back
// History memory and three-stage biquad datapath with channel interlock.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbq_back #(
  parameter int CHANNELS     = mcbq_pkg::CHANNELS_DEFAULT,
  parameter int RESULT_DEPTH = mcbq_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mcbq_pkg::queue_item_t               head,
  input  wire logic                                q_empty,
  output logic                                     q_pop,
  input  wire mcbq_pkg::coeff_t                    coeff,
  input  wire logic [$clog2(RESULT_DEPTH+1)-1:0]   res_level,
  output logic                                     res_push,
  output mcbq_pkg::result_t                        res_item
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW = $clog2(RESULT_DEPTH + 1) + 1;
  localparam logic signed [66:0] ROUND_HALF = 67'sd536870912;

  mcbq_pkg::hist_t hist_mem [CHANNELS];

  // stage 1: history read data
  logic                  s1_valid;
  mcbq_pkg::queue_item_t s1_item;
  mcbq_pkg::hist_t       s1_hist;
  // stage 2: products
  logic                  s2_valid;
  mcbq_pkg::queue_item_t s2_item;
  mcbq_pkg::hist_t       s2_hist;
  logic signed [62:0]    s2_p0;
  logic signed [62:0]    s2_p1;
  logic signed [62:0]    s2_p2;
  logic signed [63:0]    s2_p3;
  logic signed [62:0]    s2_p4;
  // stage 3: partial sums
  logic                  s3_valid;
  mcbq_pkg::queue_item_t s3_item;
  mcbq_pkg::hist_t       s3_hist;
  logic signed [64:0]    s3_ff;
  logic signed [64:0]    s3_fb;

  logic signed [30:0]    b0s;
  logic signed [62:0]    p0_n;
  logic signed [62:0]    p1_n;
  logic signed [62:0]    p2_n;
  logic signed [63:0]    p3_n;
  logic signed [62:0]    p4_n;
  logic signed [64:0]    ff_n;
  logic signed [64:0]    fb_n;
  logic signed [66:0]    total;
  logic signed [36:0]    q;
  logic signed [31:0]    y;
  logic [LW-1:0]         committed;
  logic                  credit_ok;
  logic                  hazard;
  logic                  s3_writes;
  logic [CW-1:0]         head_idx;
  logic [CW-1:0]         s3_idx;

  // ---- issue ----
  // A history-using request waits while a request of its channel that writes
  // history is still in flight (read is before write on the same edge).
  always_comb begin
    hazard = 1'b0;
    if (head.kind != mcbq_pkg::KIND_PASS) begin
      if (s1_valid && s1_item.kind != mcbq_pkg::KIND_PASS &&
          s1_item.channel == head.channel) begin
        hazard = 1'b1;
      end
      if (s2_valid && s2_item.kind != mcbq_pkg::KIND_PASS &&
          s2_item.channel == head.channel) begin
        hazard = 1'b1;
      end
      if (s3_valid && s3_item.kind != mcbq_pkg::KIND_PASS &&
          s3_item.channel == head.channel) begin
        hazard = 1'b1;
      end
    end
  end

  // Result FIFO slots reserved for everything already in the pipe.
  assign committed = LW'(res_level) + LW'(s1_valid) + LW'(s2_valid) + LW'(s3_valid);
  assign credit_ok = (committed < LW'(RESULT_DEPTH));
  assign q_pop     = !q_empty && credit_ok && !hazard;
  assign head_idx  = CW'(head.channel);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item <= head;
      s1_hist <= hist_mem[head_idx];
    end
  end

  // ---- stage 1: five multiplies ----
  assign b0s  = {1'b0, coeff.b0};
  assign p0_n = b0s * s1_item.sample;
  assign p1_n = b0s * s1_hist.in_d1;
  assign p2_n = b0s * s1_hist.in_d2;
  assign p3_n = coeff.a1 * s1_hist.out_d1;
  assign p4_n = coeff.a2 * s1_hist.out_d2;

  always_ff @(posedge clk) begin
    s2_item <= s1_item;
    s2_hist <= s1_hist;
    s2_p0   <= p0_n;
    s2_p1   <= p1_n;
    s2_p2   <= p2_n;
    s2_p3   <= p3_n;
    s2_p4   <= p4_n;
  end

  // ---- stage 2: feedforward and feedback sums ----
  assign ff_n = 65'(s2_p0) + (65'(s2_p1) <<< 1) + 65'(s2_p2);
  assign fb_n = 65'(s2_p3) + 65'(s2_p4);

  always_ff @(posedge clk) begin
    s3_item <= s2_item;
    s3_hist <= s2_hist;
    s3_ff   <= ff_n;
    s3_fb   <= fb_n;
  end

  // ---- stage 3: round half up, drop 30 fraction bits, saturate ----
  assign total = 67'(s3_ff) - 67'(s3_fb) + ROUND_HALF;
  assign q     = total[66:30];

  always_comb begin
    if (q[36:31] != {6{q[36]}}) begin
      y = q[36] ? mcbq_pkg::SAMPLE_MIN : mcbq_pkg::SAMPLE_MAX;
    end else begin
      y = q[31:0];
    end
  end

  assign s3_writes = s3_valid && (s3_item.kind != mcbq_pkg::KIND_PASS);
  assign s3_idx    = CW'(s3_item.channel);
  assign res_push  = s3_valid;

  always_comb begin
    res_item.channel = s3_item.channel;
    if (s3_item.kind == mcbq_pkg::KIND_FILTER) begin
      res_item.sample = y;
    end else begin
      res_item.sample = s3_item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_writes) begin
      if (s3_item.kind == mcbq_pkg::KIND_PRIME) begin
        hist_mem[s3_idx] <= '{in_d1: s3_item.sample, in_d2: s3_item.sample,
                              out_d1: s3_item.sample, out_d2: s3_item.sample};
      end else begin
        hist_mem[s3_idx] <= '{in_d1: s3_item.sample, in_d2: s3_hist.in_d1,
                              out_d1: y, out_d2: s3_hist.out_d1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

// File: src/multichannel_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass
// Per-channel second-order low-pass biquad, direct form I.
// ----------------------------------------------------------------------------
// Each request carries one joint sample (signed Q15.16) and a channel number;
// each result returns the channel and its filtered sample, in request order.
// The block sustains one sample per clock while results are taken. A sample
// that uses a channel's history (priming or filtering) waits while an earlier
// history-using sample of the same channel is still in the three-stage
// multiply/sum/round pipeline, so a back-to-back run on one channel stalls
// on this interlock; a sample whose channel differs from the three issued
// before it, or a pass-through sample, goes at one per clock. The filter
// computes y = b0*x + 2*b0*x1 + b0*x2 - a1*y1 - a2*y2 exactly, rounds half up
// to Q15.16 and saturates to 32 bits. A channel's first sample seeds all four
// history words and is returned unchanged; with filter_enable low a primed
// channel passes samples through without touching its history; channel
// numbers at or above CHANNELS pass through. Coefficients (a1 signed Q2.30,
// a2 signed Q1.30, b0 unsigned Q0.30) are for the user to write only while
// the block is idle; the block itself does not enforce this. No clearing
// pass is needed after reset: history is always seeded before its use.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_biquad_lowpass #(
  parameter int CHANNELS     = mcbq_pkg::CHANNELS_DEFAULT,
  parameter int QUEUE_DEPTH  = mcbq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int RESULT_DEPTH = mcbq_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration write port
  input  wire logic                                   cfg_we,
  input  wire logic [mcbq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mcbq_pkg::CFG_DATA_W-1:0]        cfg_data,
  // request side
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic [mcbq_pkg::CHAN_W-1:0]            channel,
  input  wire logic signed [mcbq_pkg::SAMPLE_W-1:0]   sample_in,
  // result side
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic [mcbq_pkg::CHAN_W-1:0]                 channel_out,
  output logic signed [mcbq_pkg::SAMPLE_W-1:0]        sample_out
);

  localparam int QW = $bits(mcbq_pkg::queue_item_t);
  localparam int RW = $bits(mcbq_pkg::result_t);

  // configuration registers
  logic             filter_enable;
  mcbq_pkg::coeff_t coeff;

  // front -> queue -> back
  logic                           q_push;
  mcbq_pkg::queue_item_t          q_item;
  logic [QW-1:0]                  q_head_bits;
  mcbq_pkg::queue_item_t          q_head;
  logic                           q_empty;
  logic                           q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

  // back -> result FIFO
  logic                              res_push;
  mcbq_pkg::result_t                 res_item;
  logic                              res_full;
  logic [RW-1:0]                     res_bits;
  mcbq_pkg::result_t                 res_head;
  logic [$clog2(RESULT_DEPTH+1)-1:0] res_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      coeff         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcbq_pkg::REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        mcbq_pkg::REG_COEFF_B0:      coeff.b0      <= cfg_data[29:0];
        mcbq_pkg::REG_COEFF_A1:      coeff.a1      <= cfg_data;
        mcbq_pkg::REG_COEFF_A2:      coeff.a2      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Classify at accept: pass, prime or filter.
  mcbq_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .channel       (channel),
    .sample_in     (sample_in),
    .filter_enable (filter_enable),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  // Request queue decouples the accept side from interlock stalls.
  mcbq_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_item),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_head_bits),
    .empty   (q_empty),
    .level   (q_level)
  );

  assign q_head = mcbq_pkg::queue_item_t'(q_head_bits);

  // History memory and arithmetic pipeline; issues only with a free result slot.
  mcbq_back #(
    .CHANNELS     (CHANNELS),
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .coeff     (coeff),
    .res_level (res_level),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // Result FIFO; credits in the back keep it from overflowing.
  mcbq_fifo #(
    .WIDTH (RW),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_bits),
    .empty   (empty),
    .level   (res_level)
  );

  assign res_head    = mcbq_pkg::result_t'(res_bits);
  assign channel_out = res_head.channel;
  assign sample_out  = res_head.sample;

  // Queue fill is visible only through full; result FIFO never fills past
  // the credit limit, so its full flag only feeds the FIFO's own guard.
  logic unused_ok;
  assign unused_ok = &{1'b0, q_level, res_full};

endmodule

`default_nettype wire

// File: src/mcbq_checker.sv
// ----------------------------------------------------------------------------
// mcbq_checker
// Port-level checks on the biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbq_checker #(
  parameter int QUEUE_DEPTH  = mcbq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int RESULT_DEPTH = mcbq_pkg::RESULT_DEPTH_DEFAULT
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 push,
  input wire logic                                 full,
  input wire logic                                 empty,
  input wire logic                                 pop,
  input wire logic [mcbq_pkg::CHAN_W-1:0]          channel_out,
  input wire logic signed [mcbq_pkg::SAMPLE_W-1:0] sample_out
);

  localparam int PW = $clog2(QUEUE_DEPTH + RESULT_DEPTH + 4) + 1;

  // requests accepted but not yet delivered
  logic [PW-1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PW'(push && !full) - PW'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(channel_out) && $stable(sample_out)))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (pending == '0) |-> empty)
    else $error("result shown with no outstanding request");

  a_full_backlog: assert property (@(posedge clk) disable iff (rst)
    full |-> (pending >= PW'(QUEUE_DEPTH)))
    else $error("full raised with a short backlog");

endmodule

bind multichannel_biquad_lowpass mcbq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .RESULT_DEPTH (RESULT_DEPTH)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .channel_out (channel_out),
  .sample_out  (sample_out)
);

`default_nettype wire
